// ===== design/crsf_pkg.sv =====
// ----------------------------------------------------------------------------
// crsf_pkg
// Shared sizes, register indexes, state codes and helpers for the capped
// range sum block built on two binary indexed trees.
// ----------------------------------------------------------------------------
package crsf_pkg;

    localparam int MAX_DAYS = 4096;
    localparam int IDX_W    = $clog2(MAX_DAYS + 1);
    localparam int ADDR_W   = $clog2(MAX_DAYS);

    localparam int ACTION_W = 1;
    localparam int DAY_W    = 13;
    localparam int AMOUNT_W = 16;
    localparam int CAP_W    = 16;
    localparam int RL_W     = 13;
    localparam int START_W  = RL_W + 1;
    localparam int COUNT_W  = 32;
    localparam int ANSWER_W = 28;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam longint CAP_LIMIT  = 65535;
    localparam int     TREE_W     = $clog2(longint'(MAX_DAYS) * CAP_LIMIT + 1);
    localparam longint ANSWER_MAX = 64'h0FFF_FFFF;

    localparam logic [ACTION_W-1:0] ACT_ADD   = 1'b0;
    localparam logic [ACTION_W-1:0] ACT_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_CAP_AFTER     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAP_BEFORE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPAIR_LENGTH = 2'd2;

    typedef enum logic [7:0] {
        ST_CLEAR = 8'b0000_0001,
        ST_IDLE  = 8'b0000_0010,
        ST_DAY   = 8'b0000_0100,
        ST_DELTA = 8'b0000_1000,
        ST_QTOT  = 8'b0001_0000,
        ST_RD    = 8'b0010_0000,
        ST_WR    = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } state_t;

    function automatic logic [IDX_W-1:0] low_bit(input logic [IDX_W-1:0] v);
        return v & (~v + 1'b1);
    endfunction

endpackage

// ===== design/crsf_ram.sv =====
// ----------------------------------------------------------------------------
// crsf_ram
// Generic simple dual-port RAM: one write port and one read port with a
// registered read.
// ----------------------------------------------------------------------------
module crsf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== design/capped_range_sum_fenwick_top.sv =====
// ----------------------------------------------------------------------------
// capped_range_sum_fenwick_top
// Per-day order counts with two binary indexed trees of capped counts.
//
// The input channel (s_*) takes add items (raise one day's count) and query
// items (best total for a repair start day). Only a query gives a result
// item on the output channel (m_*). The user must write the cap and repair
// length registers via cfg_* only while the block is idle (not enforced).
//
// After reset the block sweeps all 4096 entries of the three memories to
// zero, one entry per cycle; s_ready stays low during the sweep.
// One item is worked on at a time. An add reads its day count, works out
// the capped deltas, then walks both trees side by side; a query reads
// the full-tree total, then walks both trees summing. Each tree level takes
// a read state and a write or accumulate state on the tree memories. An add
// to a day out of range is dropped and the block stays idle.
// The result sits in an output register; the next item is accepted while
// it waits. A query that finishes while the previous result is still
// stalled waits in its last state until the output register frees up.
// ----------------------------------------------------------------------------
module capped_range_sum_fenwick_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [crsf_pkg::ACTION_W-1:0]     s_action,
    input  logic [crsf_pkg::DAY_W-1:0]        s_day,
    input  logic [crsf_pkg::AMOUNT_W-1:0]     s_amount,
    input  logic [crsf_pkg::RL_W-1:0]         s_repair_start,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [crsf_pkg::ANSWER_W-1:0]     m_answer,
    input  logic                              cfg_we,
    input  logic [crsf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [crsf_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    localparam int IDX_W  = crsf_pkg::IDX_W;
    localparam int ADDR_W = crsf_pkg::ADDR_W;
    localparam int TREE_W = crsf_pkg::TREE_W;

    crsf_pkg::state_t state_reg, state_next;

    logic [crsf_pkg::CAP_W-1:0]   cap_after_reg, cap_before_reg;
    logic [crsf_pkg::RL_W-1:0]    repair_length_reg;

    logic [ADDR_W-1:0]            clr_addr_reg;
    logic [crsf_pkg::ACTION_W-1:0] action_reg;
    logic [IDX_W-1:0]             day_idx_reg;
    logic [crsf_pkg::AMOUNT_W-1:0] amount_reg;
    logic [crsf_pkg::COUNT_W-1:0] old_reg, nv_reg;
    logic [crsf_pkg::CAP_W-1:0]   delta_full_reg, delta_red_reg;
    logic [IDX_W-1:0]             idx_full_reg, idx_red_reg;
    logic                         act_full_reg, act_red_reg;
    logic                         use_after_reg;
    logic [TREE_W-1:0]            sum_full_reg, sum_red_reg, total_full_reg;
    logic                         m_valid_reg;
    logic [crsf_pkg::ANSWER_W-1:0] m_answer_reg;

    logic                         accept;
    logic                         day_ok;
    logic [crsf_pkg::RL_W-1:0]    p_m1;
    logic [crsf_pkg::START_W-1:0] q_start;
    logic                         q_use_after;
    logic [IDX_W-1:0]             q_red_idx, q_full_idx;

    logic [crsf_pkg::COUNT_W:0]   count_sum;
    logic [crsf_pkg::CAP_W-1:0]   cf_new, cf_old, cr_new, cr_old;

    logic [IDX_W-1:0]             lb_full, lb_red, dn_full, dn_red;
    logic [IDX_W:0]               up_full, up_red;
    logic                         nact_full, nact_red;
    logic                         out_free;
    logic [TREE_W-1:0]            after_sum;
    logic [TREE_W:0]              total_sum;

    logic                         day_wr_en, day_rd_en;
    logic [ADDR_W-1:0]            day_wr_addr, day_rd_addr;
    logic [crsf_pkg::COUNT_W-1:0] day_wr_data, day_rd_data;
    logic                         full_wr_en, full_rd_en, red_wr_en, red_rd_en;
    logic [ADDR_W-1:0]            full_wr_addr, full_rd_addr, red_wr_addr, red_rd_addr;
    logic [TREE_W-1:0]            full_wr_data, full_rd_data, red_wr_data, red_rd_data;

    assign s_ready  = (state_reg == crsf_pkg::ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_answer = m_answer_reg;
    assign out_free = !m_valid_reg || m_ready;

    // Item decode at acceptance.
    assign day_ok      = (s_day != '0) && (32'(s_day) <= crsf_pkg::MAX_DAYS);
    assign p_m1        = s_repair_start - 1'b1;
    assign q_start     = crsf_pkg::START_W'(s_repair_start)
                       + crsf_pkg::START_W'(repair_length_reg);
    assign q_use_after = (32'(q_start) <= crsf_pkg::MAX_DAYS);

    always_comb begin
        if (s_repair_start == '0) begin
            q_red_idx = '0;
        end else if (32'(p_m1) > crsf_pkg::MAX_DAYS) begin
            q_red_idx = IDX_W'(crsf_pkg::MAX_DAYS);
        end else begin
            q_red_idx = IDX_W'(p_m1);
        end
        if (q_use_after && (q_start != '0)) begin
            q_full_idx = IDX_W'(q_start - 1'b1);
        end else begin
            q_full_idx = '0;
        end
    end

    // Saturating count update and growth of each capped value.
    assign count_sum = {1'b0, day_rd_data} + (crsf_pkg::COUNT_W + 1)'(amount_reg);
    assign cf_new = (nv_reg < 32'(cap_after_reg))  ? crsf_pkg::CAP_W'(nv_reg)  : cap_after_reg;
    assign cf_old = (old_reg < 32'(cap_after_reg)) ? crsf_pkg::CAP_W'(old_reg) : cap_after_reg;
    assign cr_new = (nv_reg < 32'(cap_before_reg))  ? crsf_pkg::CAP_W'(nv_reg)  : cap_before_reg;
    assign cr_old = (old_reg < 32'(cap_before_reg)) ? crsf_pkg::CAP_W'(old_reg) : cap_before_reg;

    // Tree walk steps: upward for an add, downward for a prefix sum.
    assign lb_full = crsf_pkg::low_bit(idx_full_reg);
    assign lb_red  = crsf_pkg::low_bit(idx_red_reg);
    assign up_full = {1'b0, idx_full_reg} + {1'b0, lb_full};
    assign up_red  = {1'b0, idx_red_reg} + {1'b0, lb_red};
    assign dn_full = idx_full_reg - lb_full;
    assign dn_red  = idx_red_reg - lb_red;

    always_comb begin
        if (action_reg == crsf_pkg::ACT_ADD) begin
            nact_full = act_full_reg && (32'(up_full) <= crsf_pkg::MAX_DAYS);
            nact_red  = act_red_reg && (32'(up_red) <= crsf_pkg::MAX_DAYS);
        end else begin
            nact_full = act_full_reg && (dn_full != '0);
            nact_red  = act_red_reg && (dn_red != '0);
        end
    end

    assign after_sum = use_after_reg ? (total_full_reg - sum_full_reg) : '0;
    assign total_sum = {1'b0, sum_red_reg} + {1'b0, after_sum};

    // Memory port control.
    always_comb begin
        day_wr_en   = (state_reg == crsf_pkg::ST_CLEAR) || (state_reg == crsf_pkg::ST_DELTA);
        day_wr_addr = (state_reg == crsf_pkg::ST_CLEAR) ? clr_addr_reg
                                                        : ADDR_W'(day_idx_reg - 1'b1);
        day_wr_data = (state_reg == crsf_pkg::ST_CLEAR) ? '0 : nv_reg;
        day_rd_en   = accept && (s_action == crsf_pkg::ACT_ADD) && day_ok;
        day_rd_addr = ADDR_W'(s_day - 1'b1);

        full_wr_en   = (state_reg == crsf_pkg::ST_CLEAR)
                    || ((state_reg == crsf_pkg::ST_WR) && act_full_reg
                        && (action_reg == crsf_pkg::ACT_ADD));
        full_wr_addr = (state_reg == crsf_pkg::ST_CLEAR) ? clr_addr_reg
                                                         : ADDR_W'(idx_full_reg - 1'b1);
        full_wr_data = (state_reg == crsf_pkg::ST_CLEAR) ? '0
                                                         : full_rd_data + TREE_W'(delta_full_reg);
        full_rd_en   = (accept && (s_action == crsf_pkg::ACT_QUERY))
                    || ((state_reg == crsf_pkg::ST_RD) && act_full_reg);
        full_rd_addr = (state_reg == crsf_pkg::ST_IDLE) ? ADDR_W'(crsf_pkg::MAX_DAYS - 1)
                                                        : ADDR_W'(idx_full_reg - 1'b1);

        red_wr_en   = (state_reg == crsf_pkg::ST_CLEAR)
                   || ((state_reg == crsf_pkg::ST_WR) && act_red_reg
                       && (action_reg == crsf_pkg::ACT_ADD));
        red_wr_addr = (state_reg == crsf_pkg::ST_CLEAR) ? clr_addr_reg
                                                        : ADDR_W'(idx_red_reg - 1'b1);
        red_wr_data = (state_reg == crsf_pkg::ST_CLEAR) ? '0
                                                        : red_rd_data + TREE_W'(delta_red_reg);
        red_rd_en   = (state_reg == crsf_pkg::ST_RD) && act_red_reg;
        red_rd_addr = ADDR_W'(idx_red_reg - 1'b1);
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            crsf_pkg::ST_CLEAR: begin
                if (clr_addr_reg == ADDR_W'(crsf_pkg::MAX_DAYS - 1)) begin
                    state_next = crsf_pkg::ST_IDLE;
                end
            end
            crsf_pkg::ST_IDLE: begin
                if (accept) begin
                    if (s_action == crsf_pkg::ACT_QUERY) begin
                        state_next = crsf_pkg::ST_QTOT;
                    end else if (day_ok) begin
                        state_next = crsf_pkg::ST_DAY;
                    end
                end
            end
            crsf_pkg::ST_DAY:   state_next = crsf_pkg::ST_DELTA;
            crsf_pkg::ST_DELTA: state_next = crsf_pkg::ST_RD;
            crsf_pkg::ST_QTOT:  state_next = crsf_pkg::ST_RD;
            crsf_pkg::ST_RD:    state_next = crsf_pkg::ST_WR;
            crsf_pkg::ST_WR: begin
                if (nact_full || nact_red) begin
                    state_next = crsf_pkg::ST_RD;
                end else if (action_reg == crsf_pkg::ACT_QUERY) begin
                    state_next = crsf_pkg::ST_DONE;
                end else begin
                    state_next = crsf_pkg::ST_IDLE;
                end
            end
            crsf_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = crsf_pkg::ST_IDLE;
                end
            end
            default: state_next = crsf_pkg::ST_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= crsf_pkg::ST_CLEAR;
            clr_addr_reg      <= '0;
            cap_after_reg     <= crsf_pkg::CAP_W'(1);
            cap_before_reg    <= '0;
            repair_length_reg <= crsf_pkg::RL_W'(1);
            m_valid_reg       <= 1'b0;
            act_full_reg      <= 1'b0;
            act_red_reg       <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_we) begin
                case (cfg_index)
                    crsf_pkg::CFG_CAP_AFTER:     cap_after_reg     <= cfg_wdata;
                    crsf_pkg::CFG_CAP_BEFORE:    cap_before_reg    <= cfg_wdata;
                    crsf_pkg::CFG_REPAIR_LENGTH: repair_length_reg <= cfg_wdata[crsf_pkg::RL_W-1:0];
                    default: ;
                endcase
            end

            if (state_reg == crsf_pkg::ST_CLEAR) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end

            if ((state_reg == crsf_pkg::ST_DONE) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                crsf_pkg::ST_IDLE: begin
                    if (accept) begin
                        action_reg <= s_action;
                        if (s_action == crsf_pkg::ACT_ADD) begin
                            day_idx_reg <= IDX_W'(s_day);
                            amount_reg  <= s_amount;
                        end else begin
                            idx_full_reg  <= q_full_idx;
                            idx_red_reg   <= q_red_idx;
                            act_full_reg  <= (q_full_idx != '0);
                            act_red_reg   <= (q_red_idx != '0);
                            use_after_reg <= q_use_after;
                            sum_full_reg  <= '0;
                            sum_red_reg   <= '0;
                        end
                    end
                end
                crsf_pkg::ST_DAY: begin
                    old_reg <= day_rd_data;
                    nv_reg  <= count_sum[crsf_pkg::COUNT_W] ? '1
                                                            : count_sum[crsf_pkg::COUNT_W-1:0];
                end
                crsf_pkg::ST_DELTA: begin
                    delta_full_reg <= cf_new - cf_old;
                    delta_red_reg  <= cr_new - cr_old;
                    idx_full_reg   <= day_idx_reg;
                    idx_red_reg    <= day_idx_reg;
                    act_full_reg   <= 1'b1;
                    act_red_reg    <= 1'b1;
                end
                crsf_pkg::ST_QTOT: begin
                    total_full_reg <= full_rd_data;
                end
                crsf_pkg::ST_WR: begin
                    act_full_reg <= nact_full;
                    act_red_reg  <= nact_red;
                    if (action_reg == crsf_pkg::ACT_ADD) begin
                        idx_full_reg <= IDX_W'(up_full);
                        idx_red_reg  <= IDX_W'(up_red);
                    end else begin
                        idx_full_reg <= dn_full;
                        idx_red_reg  <= dn_red;
                        if (act_full_reg) begin
                            sum_full_reg <= sum_full_reg + full_rd_data;
                        end
                        if (act_red_reg) begin
                            sum_red_reg <= sum_red_reg + red_rd_data;
                        end
                    end
                end
                crsf_pkg::ST_DONE: begin
                    if (out_free) begin
                        m_answer_reg <= (64'(total_sum) > crsf_pkg::ANSWER_MAX)
                                      ? crsf_pkg::ANSWER_W'(crsf_pkg::ANSWER_MAX)
                                      : crsf_pkg::ANSWER_W'(total_sum);
                    end
                end
                default: ;
            endcase
        end
    end

    crsf_ram #(
        .WIDTH (crsf_pkg::COUNT_W),
        .DEPTH (crsf_pkg::MAX_DAYS)
    ) u_day_ram (
        .aclk    (aclk),
        .wr_en   (day_wr_en),
        .wr_addr (day_wr_addr),
        .wr_data (day_wr_data),
        .rd_en   (day_rd_en),
        .rd_addr (day_rd_addr),
        .rd_data (day_rd_data)
    );

    crsf_ram #(
        .WIDTH (TREE_W),
        .DEPTH (crsf_pkg::MAX_DAYS)
    ) u_full_ram (
        .aclk    (aclk),
        .wr_en   (full_wr_en),
        .wr_addr (full_wr_addr),
        .wr_data (full_wr_data),
        .rd_en   (full_rd_en),
        .rd_addr (full_rd_addr),
        .rd_data (full_rd_data)
    );

    crsf_ram #(
        .WIDTH (TREE_W),
        .DEPTH (crsf_pkg::MAX_DAYS)
    ) u_red_ram (
        .aclk    (aclk),
        .wr_en   (red_wr_en),
        .wr_addr (red_wr_addr),
        .wr_data (red_wr_data),
        .rd_en   (red_rd_en),
        .rd_addr (red_rd_addr),
        .rd_data (red_rd_data)
    );

endmodule
